// ===== sv/eas_pkg.sv =====
// Shared types and constants for the earliest alarm scheduler.
// Used by eas_cell and earliest_alarm_scheduler_top; depends on nothing.
package eas_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [13:0] alarm_room;
		logic [31:0] due_time;
		logic [31:0] now_time;
	} eas_req_t;

	typedef struct packed {
		logic        fired;
		logic [13:0] fired_room;
		logic [31:0] fired_time;
		logic        insert_overflow;
		logic [31:0] expired_count;
		logic [4:0]  pending_count;
	} eas_rsp_t;

	typedef struct packed {
		logic             op;
		logic [13:0]      room;
		logic [31:0]      due;
		logic [31:0]      now;
		logic             placed;
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [31:0]      best_due;
		logic [13:0]      best_room;
		logic [31:0]      best_dist;
	} eas_wave_t;

	typedef struct packed {
		logic      active;
		eas_wave_t wave;
	} eas_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FINISH
	} eas_state_t;

endpackage

// ===== sv/eas_cell.sv =====
// One alarm slot of the scheduler chain with its registered wave stage.
// Depends on eas_pkg.
module eas_cell import eas_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] cell_idx,
	input  logic [31:0]      seq,
	input  logic             kill,
	input  eas_link_t        link_in,
	output eas_link_t        link_out,
	output logic             slot_valid
);

	logic        valid_q;
	logic [31:0] due_q;
	logic [31:0] age_q;
	logic [13:0] room_q;
	logic        act_q;
	eas_wave_t   wave_q;

	eas_wave_t   w;
	eas_wave_t   nxt;
	logic [31:0] age_gap;
	logic        take_free;
	logic        is_due;
	logic        better;

	always_comb begin
		w         = link_in.wave;
		age_gap   = seq - age_q;
		take_free = link_in.active && (w.op == OP_INSERT) && !w.placed && !valid_q;
		is_due    = link_in.active && (w.op == OP_TICK) && valid_q && (due_q <= w.now);
		better    = !w.found || (due_q < w.best_due) ||
		            ((due_q == w.best_due) && (age_gap < w.best_dist));
		nxt       = w;
		if (take_free) begin
			nxt.placed = 1'b1;
		end
		if (is_due && better) begin
			nxt.found     = 1'b1;
			nxt.idx       = cell_idx;
			nxt.best_due  = due_q;
			nxt.best_room = room_q;
			nxt.best_dist = age_gap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			act_q <= link_in.active;
			if (take_free) begin
				valid_q <= 1'b1;
			end else if (kill) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wave_q <= nxt;
		if (take_free) begin
			due_q  <= w.due;
			room_q <= w.room;
			age_q  <= seq;
		end
	end

	assign link_out.active = act_q;
	assign link_out.wave   = wave_q;
	assign slot_valid      = valid_q;

endmodule

// ===== sv/earliest_alarm_scheduler_top.sv =====
// Earliest alarm scheduler: top level with control, counters and the cell chain.
// Depends on eas_pkg and eas_cell.
// Each beat on req travels as a wave through a chain of CAPACITY cells, one cell per
// cycle; an insert lands in the lowest free slot, a tick picks the earliest due alarm
// (latest insert on equal due times). One request is in flight at a time, and the next
// request is accepted only after its wave has left the chain and its result has been
// loaded. The finished response waits in an output register, so the next request can
// be accepted while rsp is stalled.
module earliest_alarm_scheduler_top import eas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  eas_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output eas_rsp_t rsp
);

	eas_state_t state_q;
	eas_state_t state_nxt;
	logic       load_out;
	logic       req_acc;

	eas_link_t  link [CAPACITY+1];
	logic       head_act_q;
	eas_wave_t  head_q;
	eas_wave_t  done_q;
	logic [CAPACITY-1:0] kill;
	logic [CAPACITY-1:0] vld;

	logic [31:0] seq_q;
	logic [31:0] fired_total_q;
	logic [4:0]  waiting_q;
	logic        rsp_valid_q;
	eas_rsp_t    rsp_q;

	logic        do_fire;
	logic        do_store;

	assign req_acc = req_valid && !req_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (req_valid) state_nxt = ST_BUSY;
			ST_BUSY:   if (link[CAPACITY].active) state_nxt = ST_FINISH;
			ST_FINISH: if (load_out) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE:   req_stall = 1'b0;
			ST_BUSY:   req_stall = 1'b1;
			ST_FINISH: load_out  = !rsp_valid_q || !rsp_stall;
			default:   req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Launch the wave.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_act_q <= 1'b0;
		end else begin
			head_act_q <= req_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			head_q.op        <= req.opcode;
			head_q.room      <= req.alarm_room;
			head_q.due       <= req.due_time;
			head_q.now       <= req.now_time;
			head_q.placed    <= 1'b0;
			head_q.found     <= 1'b0;
			head_q.idx       <= '0;
			head_q.best_due  <= '0;
			head_q.best_room <= '0;
			head_q.best_dist <= '0;
		end
		if (link[CAPACITY].active) begin
			done_q <= link[CAPACITY].wave;
		end
	end

	assign link[0].active = head_act_q;
	assign link[0].wave   = head_q;

	assign do_fire  = load_out && (done_q.op == OP_TICK) && done_q.found;
	assign do_store = load_out && (done_q.op == OP_INSERT) && done_q.placed;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign kill[i] = do_fire && (done_q.idx == IDX_W'(i));
		eas_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (IDX_W'(i)),
			.seq        (seq_q),
			.kill       (kill[i]),
			.link_in    (link[i]),
			.link_out   (link[i+1]),
			.slot_valid (vld[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q         <= '0;
			fired_total_q <= '0;
			waiting_q     <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (do_store) begin
				seq_q     <= seq_q + 32'd1;
				waiting_q <= waiting_q + 5'd1;
			end
			if (do_fire) begin
				fired_total_q <= fired_total_q + 32'd1;
				waiting_q     <= waiting_q - 5'd1;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q.fired           <= do_fire;
			rsp_q.fired_room      <= do_fire ? done_q.best_room : 14'd0;
			rsp_q.fired_time      <= do_fire ? done_q.best_due : 32'd0;
			rsp_q.insert_overflow <= (done_q.op == OP_INSERT) && !done_q.placed;
			rsp_q.expired_count   <= do_fire ? fired_total_q + 32'd1 : fired_total_q;
			rsp_q.pending_count   <= do_fire ? waiting_q - 5'd1 :
			                         (do_store ? waiting_q + 5'd1 : waiting_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (5'($countones(vld)) == waiting_q))
		else $error("pending count differs from occupied slots");

	a_tail_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		link[CAPACITY].active |-> (state_q == ST_BUSY))
		else $error("wave left the chain outside a scan");

	a_quiet_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.fired) |-> (rsp.fired_room == 14'd0 && rsp.fired_time == 32'd0))
		else $error("non-fired beat carries alarm data");

	a_one_kill: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(kill))
		else $error("more than one slot cleared at once");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for earliest_alarm_scheduler_top: a queue-fed driver, a monitor
// and an in-house schedule predictor with random idling on both handshakes.
// Depends on eas_pkg and the scheduler RTL.
module testbench import eas_pkg::*;;

	localparam int SIDE_REQ = 0;
	localparam int SIDE_RSP = 1;
	localparam int RANDOM_ITEMS = 1000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	eas_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	eas_rsp_t rsp;

	eas_req_t pending_items[$];
	eas_rsp_t predicted_reports[$];
	int       total_items = 0;
	int       items_sent = 0;
	int       reports_seen = 0;
	int       mismatches = 0;
	int       send_gap = 0;
	int       hold_left = 0;
	int       quiet_left [2];

	bit          alarm_live  [CAPACITY];
	logic [31:0] alarm_due   [CAPACITY];
	logic [13:0] alarm_room  [CAPACITY];
	logic [31:0] alarm_stamp [CAPACITY];
	logic [31:0] insert_seq = '0;
	logic [31:0] fire_total = '0;
	int          held = 0;

	earliest_alarm_scheduler_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic eas_rsp_t advance_schedule(eas_req_t beat);
		eas_rsp_t    r;
		int          i;
		int          pick;
		bit          placed;
		logic [31:0] age_gap;
		logic [31:0] best_due;
		logic [31:0] best_dist;
		r = '0;
		pick = -1;
		placed = 1'b0;
		best_due = '0;
		best_dist = '0;
		if (beat.opcode == OP_INSERT) begin
			for (i = 0; i < CAPACITY; i++) begin
				if (!placed && !alarm_live[i]) begin
					alarm_live[i] = 1'b1;
					alarm_room[i] = beat.alarm_room;
					alarm_due[i] = beat.due_time;
					alarm_stamp[i] = insert_seq;
					insert_seq = insert_seq + 1;
					held++;
					placed = 1'b1;
				end
			end
			r.insert_overflow = !placed;
		end else begin
			for (i = 0; i < CAPACITY; i++) begin
				if (alarm_live[i] && alarm_due[i] <= beat.now_time) begin
					age_gap = insert_seq - alarm_stamp[i];
					if (pick < 0 || alarm_due[i] < best_due ||
							(alarm_due[i] == best_due && age_gap < best_dist)) begin
						pick = i;
						best_due = alarm_due[i];
						best_dist = age_gap;
					end
				end
			end
			if (pick >= 0) begin
				r.fired = 1'b1;
				r.fired_room = alarm_room[pick];
				r.fired_time = alarm_due[pick];
				alarm_live[pick] = 1'b0;
				held--;
				fire_total = fire_total + 1;
			end
		end
		r.expired_count = fire_total;
		r.pending_count = held[4:0];
		return r;
	endfunction

	// Mostly short idles, a few long ones, and occasional stretches with none.
	function automatic int idle_length(int side);
		int r;
		if (quiet_left[side] > 0) begin
			quiet_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet_left[side] = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_item(logic op, logic [13:0] room, logic [31:0] due, logic [31:0] now_t);
		eas_req_t b;
		b.opcode = op;
		b.alarm_room = (op == OP_INSERT) ? room : 14'($urandom_range(0, 16383));
		b.due_time = (op == OP_INSERT) ? due : $urandom;
		b.now_time = (op == OP_TICK) ? now_t : $urandom;
		pending_items.push_back(b);
	endtask

	task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (mismatches < 60)
			$display("MISMATCH report %0d: %s got %h want %h", reports_seen, field, got, want);
		mismatches++;
	endtask

	task automatic check_report(eas_rsp_t got, eas_rsp_t want);
		if (got.fired !== want.fired)
			flag_mismatch("fired", 32'(got.fired), 32'(want.fired));
		if (got.fired_room !== want.fired_room)
			flag_mismatch("fired_room", 32'(got.fired_room), 32'(want.fired_room));
		if (got.fired_time !== want.fired_time)
			flag_mismatch("fired_time", got.fired_time, want.fired_time);
		if (got.insert_overflow !== want.insert_overflow)
			flag_mismatch("insert_overflow", 32'(got.insert_overflow),
				32'(want.insert_overflow));
		if (got.expired_count !== want.expired_count)
			flag_mismatch("expired_count", got.expired_count, want.expired_count);
		if (got.pending_count !== want.pending_count)
			flag_mismatch("pending_count", 32'(got.pending_count), 32'(want.pending_count));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_gap = 0;
		end else begin
			if (req_valid && !req_stall) begin
				predicted_reports.push_back(advance_schedule(req));
				items_sent++;
				send_gap = idle_length(SIDE_REQ);
			end
			if (!req_valid || !req_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				reports_seen++;
				if (predicted_reports.size() == 0)
					flag_mismatch("response with nothing pending", '0, '0);
				else
					check_report(rsp, predicted_reports.pop_front());
				hold_left = idle_length(SIDE_RSP);
			end else if (hold_left == 0 && !rsp_valid && $urandom_range(0, 15) == 0) begin
				hold_left = $urandom_range(1, 8);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [31:0] clock_s;
		int          made;
		int          chunk;
		int          ins_pct;
		int          spread;
		int          k;
		int          i;
		logic [13:0] room;

		// Empty store, both ends of the time range.
		queue_item(OP_TICK, 0, 0, 32'h0000_0000);
		queue_item(OP_TICK, 0, 0, 32'hFFFF_FFFF);
		// Fill the store: field extremes and a tie at due time 5.
		queue_item(OP_INSERT, 14'd0, 32'h0000_0000, 0);
		queue_item(OP_INSERT, 14'h3FFF, 32'hFFFF_FFFF, 0);
		queue_item(OP_INSERT, 14'd9999, 32'd5, 0);
		queue_item(OP_INSERT, 14'd1234, 32'd5, 0);
		queue_item(OP_INSERT, 14'd77, 32'd5, 0);
		for (i = 5; i < CAPACITY; i++)
			queue_item(OP_INSERT, 14'(i), 32'(1000 + i), 0);
		queue_item(OP_INSERT, 14'h2AAA, 32'h5555_5555, 0);
		queue_item(OP_TICK, 0, 0, 32'd4);
		queue_item(OP_TICK, 0, 0, 32'd5);
		queue_item(OP_TICK, 0, 0, 32'd5);
		queue_item(OP_TICK, 0, 0, 32'hFFFF_FFFE);

		made = 0;
		clock_s = $urandom;
		while (made < RANDOM_ITEMS) begin
			chunk = $urandom_range(20, 80);
			ins_pct = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0: spread = 3;
				1: spread = 60;
				default: spread = 5000;
			endcase
			if ($urandom_range(0, 9) == 0)
				clock_s = 32'hFFFF_FFFF - $urandom_range(0, 200);
			for (k = 0; k < chunk; k++) begin
				room = 14'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
					: $urandom_range(0, 9999));
				if ($urandom_range(0, 19) == 0) begin
					queue_item(1'($urandom_range(0, 1)), room, $urandom, $urandom);
				end else if ($urandom_range(0, 99) < ins_pct) begin
					queue_item(OP_INSERT, room, clock_s + $urandom_range(0, spread), 0);
				end else begin
					queue_item(OP_TICK, 0, 0, clock_s);
					clock_s = clock_s + $urandom_range(0, spread);
				end
				made++;
			end
		end
		total_items = pending_items.size();

		while (items_sent < total_items)
			@(negedge clk);
		while (predicted_reports.size() > 0)
			@(negedge clk);
		repeat (2 * CAPACITY + 10) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
